>>> rtl/iir_direct_form2_fixed_point_assert.svh
// ----------------------------------------------------------------------------
// iir direct form ii assertion macros
// shared concurrent assertion forms for the filter rtl
// ----------------------------------------------------------------------------
`ifndef IIR_DIRECT_FORM2_FIXED_POINT_ASSERT_SVH
`define IIR_DIRECT_FORM2_FIXED_POINT_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define IIR_DF2_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define IIR_DF2_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/iir_df2_pkg.sv
// ----------------------------------------------------------------------------
// iir direct form ii package
// widths, register indexes, schedule constants and types of the filter
// ----------------------------------------------------------------------------
`default_nettype none

package iir_df2_pkg;

	localparam int ORDER     = 3;
	localparam int FRAC_BITS = 12;

	localparam int DATA_W  = 32;
	localparam int COEF_W  = 18;
	localparam int PROD_W  = DATA_W + COEF_W;
	localparam int EXT_W   = PROD_W + FRAC_BITS;

	localparam int NUM_REGS  = 8;
	localparam int REG_IDX_W = 3;
	localparam int REG_FF0   = 0;
	localparam int REG_FB0   = 4;

	localparam int TAP_W    = $clog2(ORDER + 1);
	localparam int DL_IDX_W = (ORDER > 1) ? $clog2(ORDER) : 1;

	// b0*w waits for the feedback sum to settle through the two mac stages
	localparam int B0_STEP   = (2 * ORDER + 1 > ORDER + 3) ? 2 * ORDER + 1 : ORDER + 3;
	localparam int LAST_STEP = B0_STEP + 2;
	localparam int STEP_W    = $clog2(LAST_STEP + 1);

	typedef logic signed [DATA_W-1:0]  data_t;
	typedef logic signed [COEF_W-1:0]  coef_t;
	typedef logic [REG_IDX_W-1:0]      reg_idx_t;

	typedef struct packed {
		logic valid;
		logic first;
		logic sub;
		logic sel_y;
	} mac_op_t;

endpackage

`default_nettype wire

>>> rtl/iir_df2_coef_regs.sv
// ----------------------------------------------------------------------------
// iir direct form ii coefficient registers
// feedforward and feedback coefficients, one write port and one read port
// ----------------------------------------------------------------------------
`default_nettype none

module iir_df2_coef_regs (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  wr_en,
	input  iir_df2_pkg::reg_idx_t wr_index,
	input  iir_df2_pkg::coef_t   wr_data,
	input  iir_df2_pkg::reg_idx_t rd_index,
	output iir_df2_pkg::coef_t   rd_coef
);
	import iir_df2_pkg::*;

	coef_t coef_q [NUM_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				coef_q[i] <= '0;
			end
		end else if (wr_en) begin
			coef_q[wr_index] <= wr_data;
		end
	end

	assign rd_coef = coef_q[rd_index];

endmodule

`default_nettype wire

>>> rtl/iir_df2_mac.sv
// ----------------------------------------------------------------------------
// iir direct form ii multiply-accumulate unit
// registered multiply, scale by the fraction bits, then add into one of two sums
// ----------------------------------------------------------------------------
`default_nettype none

module iir_df2_mac (
	input  wire                  clk,
	input  wire                  arst_n,
	input  iir_df2_pkg::mac_op_t op,
	input  iir_df2_pkg::coef_t   coef,
	input  iir_df2_pkg::data_t   data,
	output iir_df2_pkg::data_t   acc_w,
	output iir_df2_pkg::data_t   acc_y
);
	import iir_df2_pkg::*;

	logic signed [PROD_W-1:0] prod_s1;
	mac_op_t                  op_s1;
	logic signed [EXT_W-1:0]  prod_ext;
	data_t                    scaled;
	data_t                    term;
	data_t                    acc_w_q;
	data_t                    acc_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= '0;
		end else begin
			op_s1 <= op;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= coef * data;
	end

	// arithmetic shift right, keep the low word
	assign prod_ext = {{FRAC_BITS{prod_s1[PROD_W-1]}}, prod_s1};
	assign scaled   = prod_ext[FRAC_BITS+DATA_W-1:FRAC_BITS];
	assign term     = op_s1.sub ? data_t'(-scaled) : scaled;

	always_ff @(posedge clk) begin
		if (op_s1.valid) begin
			if (op_s1.sel_y) begin
				acc_y_q <= op_s1.first ? term : data_t'(acc_y_q + term);
			end else begin
				acc_w_q <= op_s1.first ? term : data_t'(acc_w_q + term);
			end
		end
	end

	assign acc_w = acc_w_q;
	assign acc_y = acc_y_q;

endmodule

`default_nettype wire

>>> rtl/iir_df2_ctrl.sv
// ----------------------------------------------------------------------------
// iir direct form ii sequencer
// steps the shared mac through the taps, holds the delay line and the output
// ----------------------------------------------------------------------------
`default_nettype none

`include "iir_direct_form2_fixed_point_assert.svh"

module iir_df2_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  iir_df2_pkg::data_t    sample_in,
	output logic                  out_valid,
	input  wire                   out_ready,
	output iir_df2_pkg::data_t    sample_out,
	output iir_df2_pkg::reg_idx_t coef_idx,
	output iir_df2_pkg::mac_op_t  op,
	output iir_df2_pkg::data_t    op_data,
	input  iir_df2_pkg::data_t    acc_w,
	input  iir_df2_pkg::data_t    acc_y
);
	import iir_df2_pkg::*;

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	data_t             x_q;
	data_t             dl_q [ORDER];
	logic              out_valid_q;
	data_t             sample_out_q;
	logic [TAP_W-1:0]  tap;
	logic              accept;
	logic              at_last;
	logic              finish;

	assign accept  = in_valid && !busy_q;
	assign at_last = (step_q == STEP_W'(LAST_STEP));
	assign finish  = busy_q && at_last && (!out_valid_q || out_ready);

	// operand selection for the current step
	always_comb begin
		op       = '0;
		coef_idx = reg_idx_t'(REG_FF0);
		op_data  = x_q;
		tap      = '0;
		priority if (!busy_q) begin
			op = '0;
		end else if (step_q == '0) begin
			op.valid = 1'b1;
			op.first = 1'b1;
			coef_idx = reg_idx_t'(REG_FB0);
		end else if (step_q <= STEP_W'(ORDER)) begin
			tap      = TAP_W'(step_q);
			op.valid = 1'b1;
			op.sub   = 1'b1;
			coef_idx = reg_idx_t'(REG_FB0) + reg_idx_t'(tap);
			op_data  = dl_q[DL_IDX_W'(tap - TAP_W'(1))];
		end else if (step_q <= STEP_W'(2 * ORDER)) begin
			tap      = TAP_W'(step_q - STEP_W'(ORDER));
			op.valid = 1'b1;
			op.sel_y = 1'b1;
			op.first = (tap == TAP_W'(1));
			coef_idx = reg_idx_t'(REG_FF0) + reg_idx_t'(tap);
			op_data  = dl_q[DL_IDX_W'(tap - TAP_W'(1))];
		end else if (step_q == STEP_W'(B0_STEP)) begin
			// feedback sum has settled by now
			op.valid = 1'b1;
			op.sel_y = 1'b1;
			coef_idx = reg_idx_t'(REG_FF0);
			op_data  = acc_w;
		end else begin
			op = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q && !at_last) begin
			step_q <= step_q + STEP_W'(1);
		end else if (finish) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= sample_in;
		end
	end

	// newest intermediate value enters at the head of the delay line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ORDER; i++) begin
				dl_q[i] <= '0;
			end
		end else if (finish) begin
			dl_q[0] <= acc_w;
			for (int i = 1; i < ORDER; i++) begin
				dl_q[i] <= dl_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			sample_out_q <= acc_y;
		end
	end

	assign in_ready   = !busy_q;
	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

	`IIR_DF2_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, busy_q && step_q == '0, "no start")
	`IIR_DF2_ASSERT_SAME(a_op_busy, clk, arst_n, op.valid, busy_q, "mac issued while idle")
	`IIR_DF2_ASSERT_SAME(a_step_range, clk, arst_n, busy_q, step_q <= STEP_W'(LAST_STEP), "bad step")
	`IIR_DF2_ASSERT_NEXT(a_finish_out, clk, arst_n, finish, out_valid_q && !busy_q, "result lost")

endmodule

`default_nettype wire

>>> rtl/iir_direct_form2_fixed_point.sv
// ----------------------------------------------------------------------------
// iir direct form ii filter, fixed point
// one sample in, one filtered sample out, through one shared multiply-accumulate
// ----------------------------------------------------------------------------
//  channel  | signals                                   | moves
//  ---------+-------------------------------------------+----------------------
//  input    | in_valid, in_ready, sample_in             | one sample per item
//  output   | out_valid, out_ready, sample_out          | one filtered sample
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data | one coefficient write
//
//  after an item is accepted it is sequenced step by step, as 2*(ORDER+1)
//  products pass one at a time through the two-stage mac; in_ready is low
//  until the item completes.
//  a finished sample sits in the output register; if it is still unread when
//  the next item completes, the sequencer holds at its last step.
//  reset clears the coefficients, the delay line and all control state.
// ----------------------------------------------------------------------------
`default_nettype none

module iir_direct_form2_fixed_point (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  iir_df2_pkg::data_t    sample_in,
	output logic                  out_valid,
	input  wire                   out_ready,
	output iir_df2_pkg::data_t    sample_out,
	input  wire                   cfg_valid,
	output logic                  cfg_ready,
	input  iir_df2_pkg::reg_idx_t cfg_index,
	input  iir_df2_pkg::coef_t    cfg_data
);
	import iir_df2_pkg::*;

	reg_idx_t coef_idx;
	coef_t    coef;
	mac_op_t  op;
	data_t    op_data;
	data_t    acc_w;
	data_t    acc_y;

	assign cfg_ready = 1'b1;

	iir_df2_coef_regs u_coef_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.rd_index (coef_idx),
		.rd_coef  (coef)
	);

	iir_df2_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.coef   (coef),
		.data   (op_data),
		.acc_w  (acc_w),
		.acc_y  (acc_y)
	);

	iir_df2_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out),
		.coef_idx   (coef_idx),
		.op         (op),
		.op_data    (op_data),
		.acc_w      (acc_w),
		.acc_y      (acc_y)
	);

endmodule

`default_nettype wire
